### hw/rtl/frt_pkg.sv
package frt_pkg;

  typedef struct packed {
    logic [30:0] frame_seq;
    logic [6:0]  fragment_count;
    logic [5:0]  fragment_index;
    logic [16:0] frame_bytes;
  } frt_in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [2:0]  slot;
    logic [18:0] write_offset;
    logic        frame_complete;
    logic [30:0] done_frame_seq;
    logic [16:0] done_frame_bytes;
  } frt_out_t;

  typedef enum logic [2:0] {
    V_ACCEPT = 3'd0,
    V_STALE  = 3'd1,
    V_ZERO   = 3'd2,
    V_DUP    = 3'd3,
    V_NOSLOT = 3'd4,
    V_BADIDX = 3'd5
  } frt_verdict_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic emit;
  } frt_cmd_t;

endpackage

### hw/rtl/frt_datapath.sv
module frt_datapath #(
  parameter int SLOTS          = 8,
  parameter int MAX_FRAGMENTS  = 64,
  parameter int FRAGMENT_BYTES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  frt_pkg::frt_cmd_t cmd,
  input  frt_pkg::frt_in_t  in_data,
  output frt_pkg::frt_out_t out_data
);
  import frt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] in_use_r;
  logic [30:0]      fid_r   [SLOTS];
  logic [6:0]       exp_r   [SLOTS];
  logic [6:0]       rcv_r   [SLOTS];
  logic [16:0]      len_r   [SLOTS];
  logic [63:0]      map_r   [SLOTS];
  logic             ld_valid_r;
  logic [30:0]      ld_frame_r;

  frt_in_t          req_r;
  logic             hit_r, free_ok_r;
  logic [SW-1:0]    hit_s_r, free_s_r;
  frt_out_t         out_r;

  logic             hit, free_ok;
  logic [SW-1:0]    hit_s, free_s;
  logic             stale_r;

  always_comb begin
    hit = 1'b0; hit_s = '0; free_ok = 1'b0; free_s = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (in_use_r[i] && fid_r[i] == req_r.frame_seq) begin
        hit = 1'b1; hit_s = SW'(i);
      end
      if (!in_use_r[i]) begin
        free_ok = 1'b1; free_s = SW'(i);
      end
    end
  end

  logic [SW-1:0] s;
  logic [63:0]   bit_m;
  logic [6:0]    rcv_nxt;
  logic          badidx, dup, acc, done;
  logic [18:0]   offs;
  logic [16:0]   dlen;

  always_comb begin
    s      = hit_r ? hit_s_r : free_s_r;
    bit_m  = 64'd1 << req_r.fragment_index;
    badidx = 1'b0; dup = 1'b0;
    if (hit_r) begin
      badidx = {1'b0, req_r.fragment_index} >= exp_r[s];
      dup    = |(map_r[s] & bit_m);
    end else begin
      badidx = req_r.fragment_count > 7'(MAX_FRAGMENTS) ||
               {1'b0, req_r.fragment_index} >= req_r.fragment_count;
    end
    acc     = !stale_r && req_r.fragment_count != 7'd0 && !badidx && !dup &&
              (hit_r || free_ok_r);
    rcv_nxt = (hit_r ? rcv_r[s] : 7'd0) + 7'd1;
    done    = rcv_nxt == (hit_r ? exp_r[s] : req_r.fragment_count);
    dlen    = hit_r ? len_r[s] : req_r.frame_bytes;
    offs    = 19'(((32'(s) * 32'(MAX_FRAGMENTS)) + 32'(req_r.fragment_index)) *
                  32'(FRAGMENT_BYTES));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_data;
      stale_r <= 1'b0;
    end
    if (cmd.lookup) begin
      hit_r     <= hit;
      hit_s_r   <= hit_s;
      free_ok_r <= free_ok;
      free_s_r  <= free_s;
      stale_r   <= ld_valid_r && req_r.frame_seq <= ld_frame_r;
    end
    if (cmd.update) begin
      out_r <= '0;
      if (stale_r) out_r.verdict <= V_STALE;
      else if (req_r.fragment_count == 7'd0) out_r.verdict <= V_ZERO;
      else if (badidx) out_r.verdict <= V_BADIDX;
      else if (dup) out_r.verdict <= V_DUP;
      else if (!hit_r && !free_ok_r) out_r.verdict <= V_NOSLOT;
      else begin
        out_r.verdict        <= V_ACCEPT;
        out_r.slot           <= 3'(s);
        out_r.write_offset   <= offs;
        out_r.frame_complete <= done;
        if (done) begin
          out_r.done_frame_seq   <= req_r.frame_seq;
          out_r.done_frame_bytes <= dlen;
        end
      end
      if (acc) begin
        map_r[s] <= (hit_r ? map_r[s] : 64'd0) | bit_m;
        rcv_r[s] <= rcv_nxt;
        if (!hit_r) begin
          fid_r[s] <= req_r.frame_seq;
          exp_r[s] <= req_r.fragment_count;
          len_r[s] <= req_r.frame_bytes;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= '0;
      ld_valid_r <= 1'b0;
      ld_frame_r <= '0;
    end else if (cmd.update && acc) begin
      if (done) begin
        ld_valid_r <= 1'b1;
        ld_frame_r <= req_r.frame_seq;
        for (int i = 0; i < SLOTS; i++) begin
          if (in_use_r[i] && fid_r[i] <= req_r.frame_seq) in_use_r[i] <= 1'b0;
        end
        in_use_r[s] <= 1'b0;
      end else begin
        in_use_r[s] <= 1'b1;
      end
    end
  end

  assign out_data = out_r;

endmodule

### hw/rtl/frt_ctrl.sv
module frt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output frt_pkg::frt_cmd_t cmd
);
  import frt_pkg::*;

  typedef enum logic [1:0] {IDLE, LOOKUP, UPDATE, EMIT} state_t;
  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      unique case (state_r)
        IDLE:    if (start) state_r <= LOOKUP;
        LOOKUP:  state_r <= UPDATE;
        UPDATE:  state_r <= EMIT;
        EMIT:    state_r <= IDLE;
        default: state_r <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = state_r == IDLE && start;
    cmd.lookup = state_r == LOOKUP;
    cmd.update = state_r == UPDATE;
    cmd.emit   = state_r == EMIT;
  end

  assign busy      = state_r != IDLE;
  assign out_valid = cmd.emit;

endmodule

### hw/rtl/fragment_reassembly_tracker_top.sv
// out_valid comes from the EMIT state, after LOOKUP and UPDATE; start is ignored
// while busy, so a new request is taken only once the last one has been emitted.
// Steps: capture, slot lookup over the slot table, verdict/update, output.
// The receiver cannot stall; out_valid is high for one cycle per request.
// Reset (rst_n low, synchronous) frees all slots and forgets the last
// completed frame.
module fragment_reassembly_tracker_top #(
  parameter int SLOTS          = 8,
  parameter int MAX_FRAGMENTS  = 64,
  parameter int FRAGMENT_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  frt_pkg::frt_in_t  in_data,
  output logic              out_valid,
  output frt_pkg::frt_out_t out_data
);
  import frt_pkg::*;

  frt_cmd_t cmd;

  frt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd)
  );

  frt_datapath #(
    .SLOTS(SLOTS), .MAX_FRAGMENTS(MAX_FRAGMENTS), .FRAGMENT_BYTES(FRAGMENT_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data), .out_data(out_data)
  );

endmodule
